// ----- rtl/core/ddo_pkg.sv -----
// ddo_pkg: shared types and constants for the differential drive odometry block
// no dependencies
package ddo_pkg;

  localparam int unsigned CfgWidth = 24;
  localparam int unsigned PosWidth = 48;

  localparam logic [0:0] RegTravel = 1'b0;
  localparam logic [0:0] RegTurn   = 1'b1;

  localparam logic [23:0] TravelReset = 24'd28149;
  localparam logic [23:0] TurnReset   = 24'd2908789;

  localparam logic signed [33:0] CordicK = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [15:0]        heading;
  } out_item_t;

  // one queue entry between front and back: the wheel count changes
  typedef struct packed {
    logic signed [31:0] dl;
    logic signed [31:0] dr;
  } delta_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/ddo_front.sv -----
// ddo_front: accepts encoder counts and forms wrapped count changes
// depends on ddo_pkg
module ddo_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ddo_pkg::in_item_t in_data_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output ddo_pkg::delta_t   q_data_o
);
  import ddo_pkg::*;

  logic [31:0] last_l_q, last_r_q;
  logic        full_q;
  delta_t      ent_q;
  logic        acc;

  assign in_ready_o = !full_q || q_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign q_valid_o  = full_q;
  assign q_data_o   = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= '0;
      last_r_q <= '0;
      full_q   <= 1'b0;
    end else begin
      if (acc) begin
        last_l_q <= in_data_i.left_count;
        last_r_q <= in_data_i.right_count;
        full_q   <= 1'b1;
      end else if (q_ready_i) begin
        full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ent_q.dl <= in_data_i.left_count - last_l_q;
      ent_q.dr <= in_data_i.right_count - last_r_q;
    end
  end

endmodule

// ----- rtl/core/ddo_back.sv -----
// ddo_back: sequencer for wheel travel, turn, cordic and pose update
// depends on ddo_pkg
module ddo_back #(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned POS_FRAC_BITS = 16,
  parameter int unsigned TRIG_STEPS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  ddo_pkg::delta_t    q_data_i,
  input  logic [23:0]        travel_i,
  input  logic [23:0]        turn_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ddo_pkg::out_item_t out_data_o
);
  import ddo_pkg::*;

  localparam int unsigned Sh = POS_FRAC_BITS + 16;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WHEEL = 7'b0000010,
    S_TURN  = 7'b0000100,
    S_DIR   = 7'b0001000,
    S_ROT   = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_ACC   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [ANGLE_BITS-1:0] head_q;
  logic signed [47:0] acc_x_q, acc_y_q;
  logic signed [56:0] wl_q, wr_q;
  logic signed [57:0] mean_q, diff_q;
  logic signed [63:0] turn_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [33:0] z_q;
  logic               flip_q;
  logic [4:0]         step_q;
  logic signed [63:0] px_hi_q, py_hi_q, px_lo_q, py_lo_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // turn product pieces
  logic signed [57-Sh:0] hi_part;
  logic [63:0]        lo_part;
  logic signed [63:0] turn_c;
  logic signed [63:0] half_c;
  logic [ANGLE_BITS-1:0] dir_c;
  logic [31:0]        ang_c, ang_f;
  logic               flip_c;
  logic signed [33:0] xs, ys;
  logic signed [33:0] atan_c;
  logic signed [27:0] m_hi;
  logic signed [30:0] m_lo;
  logic signed [63:0] sx, sy;
  logic signed [63:0] nx, ny;
  logic [ANGLE_BITS-1:0] head_n;

  always_comb begin
    hi_part = (58 - Sh)'(diff_q >>> Sh);
    lo_part = 64'(diff_q[Sh-1:0]) * 64'(turn_i);
    turn_c  = 64'(hi_part) * 64'($signed({1'b0, turn_i})) + $signed(lo_part >> Sh);
    half_c  = turn_q >>> 1;
    dir_c   = head_q + half_c[ANGLE_BITS-1:0];
    ang_c   = 32'(dir_c) << (32 - ANGLE_BITS);
    flip_c  = ang_c[31] ^ ang_c[30];
    ang_f   = flip_c ? ang_c - 32'h80000000 : ang_c;
    xs      = cx_q >>> step_q;
    ys      = cy_q >>> step_q;
    atan_c  = $signed({2'b00, atan_lut(step_q)});
    m_hi    = 28'(mean_q >>> 30);
    m_lo    = $signed({1'b0, mean_q[29:0]});
    sx      = (px_hi_q) + (px_lo_q >>> 30);
    sy      = (py_hi_q) + (py_lo_q >>> 30);
    nx      = 64'(acc_x_q) + sx;
    ny      = 64'(acc_y_q) + sy;
    head_n  = head_q + turn_q[ANGLE_BITS-1:0];
  end

  function automatic logic signed [47:0] sat(input logic signed [63:0] v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -64'sh0000_8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  assign q_ready_o   = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (q_valid_i) state_d = S_WHEEL;
      S_WHEEL: state_d = S_TURN;
      S_TURN:  state_d = S_DIR;
      S_DIR:   state_d = S_ROT;
      S_ROT:   if (32'(step_q) == TRIG_STEPS - 1) state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == S_ACC && (!out_valid_q || out_ready_i)) begin
        acc_x_q     <= sat(nx);
        acc_y_q     <= sat(ny);
        head_q      <= head_n;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        wl_q <= 57'(q_data_i.dl) * $signed({1'b0, travel_i});
        wr_q <= 57'(q_data_i.dr) * $signed({1'b0, travel_i});
      end
      S_WHEEL: begin
        mean_q <= (58'(wl_q) + 58'(wr_q)) >>> 1;
        diff_q <= 58'(wr_q) - 58'(wl_q);
      end
      S_TURN: turn_q <= turn_c;
      S_DIR: begin
        flip_q <= flip_c;
        z_q    <= 34'($signed(ang_f));
        cx_q   <= CordicK;
        cy_q   <= '0;
        step_q <= '0;
      end
      S_ROT: begin
        if (!z_q[33]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          z_q  <= z_q - atan_c;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          z_q  <= z_q + atan_c;
        end
        step_q <= step_q + 5'd1;
      end
      S_MUL: begin
        px_hi_q <= 64'(m_hi) * 64'(flip_q ? -cx_q : cx_q);
        py_hi_q <= 64'(m_hi) * 64'(flip_q ? -cy_q : cy_q);
        px_lo_q <= 64'(m_lo) * 64'(flip_q ? -cx_q : cx_q);
        py_lo_q <= 64'(m_lo) * 64'(flip_q ? -cy_q : cy_q);
      end
      S_ACC: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.pos_x   <= sat(nx);
          out_q.pos_y   <= sat(ny);
          if (ANGLE_BITS >= 16) out_q.heading <= 16'(head_n >> (ANGLE_BITS - 16));
          else out_q.heading <= 16'(32'(head_n) << (16 - ANGLE_BITS));
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIR |=> step_q == 5'd0) else $error("cordic step not cleared");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i && q_ready_o |=> state_q == S_WHEEL) else $error("queue entry lost");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_ACC) else $error("stray result");
`endif

endmodule

// ----- rtl/core/differential_drive_odometry.sv -----
// differential_drive_odometry: top level wheel odometry block
// depends on ddo_pkg, ddo_front, ddo_back
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    left_count, right_count
// out       output     out_valid/out_ready  pos_x, pos_y, heading
// cfg       input      cfg_we               cfg_idx, cfg_data (24 bit)
//
// in the back end each transaction steps through the wheel, turn, direction, cordic
// rotation, multiply and accumulate states; the cordic loop runs one rotation per cycle
// the front stage holds one transaction, so one new input can be taken while the back works
// reset clears pose, last counts and registers to their defaults; no clearing pass
// a result waiting in the output register stalls only the final pose update
module differential_drive_odometry #(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned POS_FRAC_BITS = 16,
  parameter int unsigned TRIG_STEPS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ddo_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ddo_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i
);
  import ddo_pkg::*;

  // configuration registers
  logic [23:0] travel_q, turn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      travel_q <= TravelReset;
      turn_q   <= TurnReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTravel: travel_q <= cfg_data_i;
        RegTurn:   turn_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // queue between front and back
  logic   q_valid, q_ready;
  delta_t q_data;

  ddo_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_data_o  (q_data)
  );

  ddo_back #(
    .ANGLE_BITS    (ANGLE_BITS),
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .TRIG_STEPS    (TRIG_STEPS)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .travel_i    (travel_q),
    .turn_i      (turn_q),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
